// ===== hdl/hex20_element_connectivity_unit_macros.svh =====
// Assertion helpers shared by the connectivity unit.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef HEX20_ELEMENT_CONNECTIVITY_UNIT_MACROS_SVH
`define HEX20_ELEMENT_CONNECTIVITY_UNIT_MACROS_SVH

// Check that a property holds at every edge.
`define H20_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define H20_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hex20_pkg.sv =====
// ----------------------------------------------------------------------------
// hex20_pkg
// Widths, register indexes and the node slot table of the hex20 unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hex20_pkg;

    localparam int MAX_CELLS_DEF = 256;
    localparam int ELEM_W        = 24;
    localparam int NODE_W        = 27;
    localparam int SLOT_W        = 5;
    localparam int RAW_W         = 9;
    localparam int DIV_STEPS     = 4;

    localparam logic [SLOT_W-1:0] LAST_SLOT = 5'd19;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_X_CELLS  = 2'd0;
    localparam logic [1:0] REG_Y_CELLS  = 2'd1;
    localparam logic [1:0] REG_Z_CELLS  = 2'd2;
    localparam logic [1:0] REG_PERIODIC = 2'd3;

    // node blocks
    localparam logic [1:0] BLK_CORNER = 2'd0;
    localparam logic [1:0] BLK_XMID   = 2'd1;
    localparam logic [1:0] BLK_YMID   = 2'd2;
    localparam logic [1:0] BLK_ZMID   = 2'd3;

    typedef struct packed {
        logic [1:0] blk;
        logic       kup;
        logic       jup;
        logic       iup;
    } slot_ent_t;

    // block and +1 offsets (k, j, i) of each slot
    function automatic slot_ent_t slot_map(input logic [SLOT_W-1:0] slot);
        slot_ent_t e;
        case (slot)
            5'd0:    e = '{BLK_CORNER, 1'b0, 1'b0, 1'b0};
            5'd1:    e = '{BLK_CORNER, 1'b0, 1'b0, 1'b1};
            5'd2:    e = '{BLK_CORNER, 1'b0, 1'b1, 1'b1};
            5'd3:    e = '{BLK_CORNER, 1'b0, 1'b1, 1'b0};
            5'd4:    e = '{BLK_CORNER, 1'b1, 1'b0, 1'b0};
            5'd5:    e = '{BLK_CORNER, 1'b1, 1'b0, 1'b1};
            5'd6:    e = '{BLK_CORNER, 1'b1, 1'b1, 1'b1};
            5'd7:    e = '{BLK_CORNER, 1'b1, 1'b1, 1'b0};
            5'd8:    e = '{BLK_XMID,   1'b0, 1'b0, 1'b0};
            5'd9:    e = '{BLK_YMID,   1'b0, 1'b0, 1'b1};
            5'd10:   e = '{BLK_XMID,   1'b0, 1'b1, 1'b0};
            5'd11:   e = '{BLK_YMID,   1'b0, 1'b0, 1'b0};
            5'd12:   e = '{BLK_XMID,   1'b1, 1'b0, 1'b0};
            5'd13:   e = '{BLK_YMID,   1'b1, 1'b0, 1'b1};
            5'd14:   e = '{BLK_XMID,   1'b1, 1'b1, 1'b0};
            5'd15:   e = '{BLK_YMID,   1'b1, 1'b0, 1'b0};
            5'd16:   e = '{BLK_ZMID,   1'b0, 1'b0, 1'b0};
            5'd17:   e = '{BLK_ZMID,   1'b0, 1'b0, 1'b1};
            5'd18:   e = '{BLK_ZMID,   1'b0, 1'b1, 1'b1};
            5'd19:   e = '{BLK_ZMID,   1'b0, 1'b1, 1'b0};
            default: e = '{BLK_CORNER, 1'b0, 1'b0, 1'b0};
        endcase
        return e;
    endfunction

endpackage

// ===== hdl/hex20_div.sv =====
// ----------------------------------------------------------------------------
// hex20_div
// Pipelined restoring divider, STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex20_div #(
    parameter int W     = 24,
    parameter int DW    = 9,
    parameter int STEPS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [W-1:0]  dividend,
    input  logic [DW-1:0] divisor,
    output logic          out_valid,
    output logic [W-1:0]  quotient,
    output logic [DW-1:0] remainder
);

    localparam int NST = (W + STEPS - 1) / STEPS;

    logic          v_reg   [NST];
    logic [DW-1:0] rem_reg [NST];
    logic [W-1:0]  wk_reg  [NST];
    logic          v_next  [NST];
    logic [DW-1:0] rem_next[NST];
    logic [W-1:0]  wk_next [NST];

    always_comb
    begin
        logic [DW-1:0] r;
        logic [W-1:0]  w;
        logic [DW:0]   tt;
        for (int s = 0; s < NST; s++)
        begin
            if (s == 0)
            begin
                r         = '0;
                w         = dividend;
                v_next[s] = in_valid;
            end
            else
            begin
                r         = rem_reg[s-1];
                w         = wk_reg[s-1];
                v_next[s] = v_reg[s-1];
            end
            for (int t = 0; t < STEPS; t++)
            begin
                if (s * STEPS + t < W)
                begin
                    tt = {r, w[W-1]};
                    if (tt >= {1'b0, divisor})
                    begin
                        tt = tt - {1'b0, divisor};
                        w  = {w[W-2:0], 1'b1};
                    end
                    else
                    begin
                        w  = {w[W-2:0], 1'b0};
                    end
                    r = tt[DW-1:0];
                end
            end
            rem_next[s] = r;
            wk_next[s]  = w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int s = 0; s < NST; s++)
            begin
                v_reg[s] <= v_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < NST; s++)
            begin
                rem_reg[s] <= rem_next[s];
                wk_reg[s]  <= wk_next[s];
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign quotient  = wk_reg[NST-1];
    assign remainder = rem_reg[NST-1];

endmodule

// ===== hdl/hex20_element_connectivity_unit.sv =====
// ----------------------------------------------------------------------------
// hex20_element_connectivity_unit
// Path: input, both dividers, coordinate, product, emitter, output register;
//   the 20 node words of an element follow on consecutive cycles, an error
//   gives a single word; the next element loads as the last word goes out.
// Reset: rst_n clears the pipeline valids and the emitter; registers return
//   to x/y/z cells = 1 and open numbering.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex20_element_connectivity_unit #(
    parameter int MAX_CELLS = hex20_pkg::MAX_CELLS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // element command
    input  logic                           start,
    output logic                           busy,
    input  logic [hex20_pkg::ELEM_W-1:0]   element_index,
    // node words
    output logic                           result_valid,
    output logic [hex20_pkg::NODE_W-1:0]   node_index,
    output logic [hex20_pkg::SLOT_W-1:0]   local_slot,
    output logic                           last_node,
    output logic                           index_error
);

    import hex20_pkg::*;

    `include "hex20_element_connectivity_unit_macros.svh"

    localparam int CW     = $clog2(MAX_CELLS + 1);
    localparam int EW     = (CW > RAW_W) ? CW : RAW_W;
    localparam int NW     = NODE_W;
    localparam int DIV_ST = (ELEM_W + DIV_STEPS - 1) / DIV_STEPS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [RAW_W-1:0] x_raw_reg, y_raw_reg, z_raw_reg;
    logic             per_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_raw_reg <= RAW_W'(1);
            y_raw_reg <= RAW_W'(1);
            z_raw_reg <= RAW_W'(1);
            per_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_X_CELLS:  x_raw_reg <= pwdata[RAW_W-1:0];
                REG_Y_CELLS:  y_raw_reg <= pwdata[RAW_W-1:0];
                REG_Z_CELLS:  z_raw_reg <= pwdata[RAW_W-1:0];
                REG_PERIODIC: per_reg   <= pwdata[0];
                default:      per_reg   <= per_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_X_CELLS:  prdata = 32'(x_raw_reg);
            REG_Y_CELLS:  prdata = 32'(y_raw_reg);
            REG_Z_CELLS:  prdata = 32'(z_raw_reg);
            REG_PERIODIC: prdata = 32'(per_reg);
            default:      prdata = '0;
        endcase
    end

    // Clamp a cell count to 1..MAX_CELLS: zero acts as one, large saturates.
    function automatic logic [CW-1:0] eff_cells(input logic [RAW_W-1:0] raw);
        logic [EW-1:0] r;
        r = EW'(raw);
        if (r == '0)
            return CW'(1);
        else if (r > EW'(MAX_CELLS))
            return CW'(MAX_CELLS);
        else
            return CW'(r);
    endfunction

    logic [CW-1:0] nx, ny, nz;
    assign nx = eff_cells(x_raw_reg);
    assign ny = eff_cells(y_raw_reg);
    assign nz = eff_cells(z_raw_reg);

    // ------------------------------------------------------------------
    // Grid constants: three registered steps after a register write.
    // Only the late stages read them, so they settle long before use.
    // ------------------------------------------------------------------
    logic [NW-1:0] pl_reg, pc_reg, px_reg, py_reg;
    logic [NW-1:0] cnt_reg, corn_reg, xm_reg, ym_reg;
    logic [NW-1:0] plane_reg [3];
    logic [NW-1:0] row_reg   [3];
    logic [NW-1:0] base_reg  [4];
    logic [NW-1:0] nx_w, ny_w, nz_w;

    assign nx_w = NW'(nx);
    assign ny_w = NW'(ny);
    assign nz_w = NW'(nz);

    always_ff @(posedge clk)
    begin
        // plane sizes
        pl_reg   <= nx_w * ny_w;
        pc_reg   <= (nx_w + NW'(1)) * (ny_w + NW'(1));
        px_reg   <= nx_w * (ny_w + NW'(1));
        py_reg   <= (nx_w + NW'(1)) * ny_w;
        // block sizes
        cnt_reg  <= pl_reg * nz_w;
        corn_reg <= pc_reg * (nz_w + NW'(1));
        xm_reg   <= px_reg * (nz_w + NW'(1));
        ym_reg   <= py_reg * (nz_w + NW'(1));
        // mode-selected strides and block bases
        plane_reg[0] <= per_reg ? pl_reg : pc_reg;
        plane_reg[1] <= per_reg ? pl_reg : px_reg;
        plane_reg[2] <= per_reg ? pl_reg : py_reg;
        row_reg[0]   <= per_reg ? nx_w : nx_w + NW'(1);
        row_reg[1]   <= nx_w;
        row_reg[2]   <= per_reg ? nx_w : nx_w + NW'(1);
        base_reg[0]  <= '0;
        base_reg[1]  <= per_reg ? cnt_reg : corn_reg;
        base_reg[2]  <= per_reg ? (cnt_reg << 1) : corn_reg + xm_reg;
        base_reg[3]  <= per_reg ? (cnt_reg << 1) + cnt_reg : corn_reg + xm_reg + ym_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves together; hold all of them
    // while a finished element waits for the emitter.
    // ------------------------------------------------------------------
    logic adv;
    logic load_ok;
    logic sp_valid_reg;
    logic em_active_reg;
    logic em_err_reg;
    logic [SLOT_W-1:0] em_slot_reg;
    logic em_last;

    assign em_last = em_err_reg || (em_slot_reg == LAST_SLOT);
    assign load_ok = !em_active_reg || em_last;
    assign adv     = !sp_valid_reg || load_ok;
    assign busy    = !adv;

    // input stage
    logic              s0_valid_reg;
    logic [ELEM_W-1:0] s0_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (adv)
            s0_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (adv && start)
            s0_e_reg <= element_index;
    end

    // ------------------------------------------------------------------
    // Split the element number: e / nx gives i, then / ny gives j and k.
    // ------------------------------------------------------------------
    logic              d1_valid, d2_valid;
    logic [ELEM_W-1:0] d1_quo, d2_quo;
    logic [CW-1:0]     d1_rem, d2_rem;
    logic [CW-1:0]     idl_reg [DIV_ST];

    hex20_div #(.W(ELEM_W), .DW(CW), .STEPS(DIV_STEPS)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s0_valid_reg),
        .dividend  (s0_e_reg),
        .divisor   (nx),
        .out_valid (d1_valid),
        .quotient  (d1_quo),
        .remainder (d1_rem)
    );

    hex20_div #(.W(ELEM_W), .DW(CW), .STEPS(DIV_STEPS)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d1_valid),
        .dividend  (d1_quo),
        .divisor   (ny),
        .out_valid (d2_valid),
        .quotient  (d2_quo),
        .remainder (d2_rem)
    );

    // carry i alongside the second divider
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idl_reg[0] <= d1_rem;
            for (int s = 1; s < DIV_ST; s++)
            begin
                idl_reg[s] <= idl_reg[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Coordinate stage: range check and neighbor coordinates.
    // k >= nz is the same test as e >= nx*ny*nz.
    // ------------------------------------------------------------------
    logic          sc_valid_reg;
    logic          sc_err_reg;
    logic [CW-1:0] sc_i_reg, sc_j_reg, sc_k_reg;
    logic [CW-1:0] sc_i1_reg, sc_j1_reg, sc_k1_reg;

    function automatic logic [CW-1:0] next_coord(input logic [CW-1:0] c,
                                                 input logic [CW-1:0] n,
                                                 input logic          wrap);
        logic [CW:0] p;
        p = {1'b0, c} + (CW+1)'(1);
        if (wrap && (p == {1'b0, n}))
            return '0;
        else
            return p[CW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_valid_reg <= 1'b0;
        else if (adv)
            sc_valid_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_err_reg <= d2_quo >= ELEM_W'(nz);
            sc_i_reg   <= idl_reg[DIV_ST-1];
            sc_j_reg   <= d2_rem;
            sc_k_reg   <= d2_quo[CW-1:0];
            sc_i1_reg  <= next_coord(idl_reg[DIV_ST-1], nx, per_reg);
            sc_j1_reg  <= next_coord(d2_rem, ny, per_reg);
            sc_k1_reg  <= next_coord(d2_quo[CW-1:0], nz, per_reg);
        end
    end

    // ------------------------------------------------------------------
    // Product stage: plane and row offsets for each block group
    // (corner/z-mid, x-mid, y-mid) at k, k+1, j, j+1.
    // ------------------------------------------------------------------
    logic          sp_err_reg;
    logic [CW-1:0] sp_i_reg, sp_i1_reg;
    logic [NW-1:0] sp_kt_reg [6];
    logic [NW-1:0] sp_jt_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sp_valid_reg <= 1'b0;
        else if (adv)
            sp_valid_reg <= sc_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp_err_reg <= sc_err_reg;
            sp_i_reg   <= sc_i_reg;
            sp_i1_reg  <= sc_i1_reg;
            for (int g = 0; g < 3; g++)
            begin
                sp_kt_reg[2*g]   <= NW'(sc_k_reg)  * plane_reg[g];
                sp_kt_reg[2*g+1] <= NW'(sc_k1_reg) * plane_reg[g];
                sp_jt_reg[2*g]   <= NW'(sc_j_reg)  * row_reg[g];
                sp_jt_reg[2*g+1] <= NW'(sc_j1_reg) * row_reg[g];
            end
        end
    end

    // ------------------------------------------------------------------
    // Emitter: hold one element and send a node word per cycle.
    // Take the next element in the cycle the last word goes out.
    // ------------------------------------------------------------------
    logic [CW-1:0] em_i_reg, em_i1_reg;
    logic [NW-1:0] em_kt_reg [6];
    logic [NW-1:0] em_jt_reg [6];
    logic          em_load;

    assign em_load = sp_valid_reg && load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_active_reg <= 1'b0;
            em_slot_reg   <= '0;
            em_err_reg    <= 1'b0;
        end
        else if (em_load)
        begin
            em_active_reg <= 1'b1;
            em_slot_reg   <= '0;
            em_err_reg    <= sp_err_reg;
        end
        else if (em_active_reg && em_last)
        begin
            em_active_reg <= 1'b0;
            em_err_reg    <= 1'b0;
        end
        else if (em_active_reg)
        begin
            em_slot_reg   <= em_slot_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (em_load)
        begin
            em_i_reg  <= sp_i_reg;
            em_i1_reg <= sp_i1_reg;
            for (int n = 0; n < 6; n++)
            begin
                em_kt_reg[n] <= sp_kt_reg[n];
                em_jt_reg[n] <= sp_jt_reg[n];
            end
        end
    end

    // slot decode and node sum
    slot_ent_t     ent;
    logic [1:0]    grp;
    logic [2:0]    kt_sel, jt_sel;
    logic [NW-1:0] node_sum;

    always_comb
    begin
        ent = slot_map(em_slot_reg);
        case (ent.blk)
            BLK_XMID: grp = 2'd1;
            BLK_YMID: grp = 2'd2;
            default:  grp = 2'd0;
        endcase
        kt_sel   = {grp, ent.kup};
        jt_sel   = {grp, ent.jup};
        node_sum = base_reg[ent.blk]
                 + em_kt_reg[kt_sel]
                 + em_jt_reg[jt_sel]
                 + NW'(ent.iup ? em_i1_reg : em_i_reg);
    end

    // output register: one word per cycle, no back-pressure
    logic              out_valid_reg;
    logic [NW-1:0]     out_node_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_last_reg, out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= em_active_reg;
    end

    always_ff @(posedge clk)
    begin
        if (em_err_reg)
        begin
            out_node_reg <= '0;
            out_slot_reg <= '0;
        end
        else
        begin
            out_node_reg <= node_sum;
            out_slot_reg <= em_slot_reg;
        end
        out_last_reg <= em_last;
        out_err_reg  <= em_err_reg;
    end

    assign result_valid = out_valid_reg;
    assign node_index   = out_node_reg;
    assign local_slot   = out_slot_reg;
    assign last_node    = out_last_reg;
    assign index_error  = out_err_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `H20_ASSERT(a_err_single, !(result_valid && index_error) || (last_node && node_index == '0), "error word must be a lone zero word")
    `H20_ASSERT(a_last_slot, !(result_valid && last_node && !index_error) || (local_slot == LAST_SLOT), "last word of an element must be slot 19")
    `H20_ASSERT(a_busy_emit, !busy || em_active_reg, "stall without an element in the emitter")
    `H20_ASSERT_NEXT(a_burst, result_valid && !last_node, result_valid && (local_slot == $past(local_slot) + 5'd1), "element words must be back to back in slot order")

endmodule
